// ===== rtl/ecd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, constants and calendar helpers for the epoch to calendar
// date converter: divider phases, month lengths and the leap year rule.
// ----------------------------------------------------------------------------
package ecd_pkg;

    // Datapath widths.
    localparam int QUO_W  = 32;
    localparam int PROD_W = 64;
    localparam int REM_W  = 6;
    localparam int DAYS_W = 16;
    localparam int YEAR_W = 12;
    localparam int MON_W  = 4;
    localparam int YLEN_W = 9;
    localparam int MLEN_W = 5;

    // Divider phases, one per constant division.
    typedef logic [1:0] t_phase;
    localparam t_phase PH_SEC  = 2'd0;
    localparam t_phase PH_MIN  = 2'd1;
    localparam t_phase PH_HOUR = 2'd2;
    localparam t_phase PH_WDAY = 2'd3;

    // Divisors.
    localparam logic [REM_W-1:0] SECS_PER_MIN  = 6'd60;
    localparam logic [REM_W-1:0] MINS_PER_HOUR = 6'd60;
    localparam logic [REM_W-1:0] HOURS_PER_DAY = 6'd24;
    localparam logic [REM_W-1:0] DAYS_PER_WEEK = 6'd7;

    // Reciprocals, rounded up, for exact division by multiplication. Division
    // by 60 is a shift by 2 then division by 15 (operand below 2^30, product
    // shifted by 34); by 24 a shift by 3 then division by 3 (operand below
    // 2^18, shift by 20); by 7 directly (operand below 2^16, shift by 19).
    localparam logic [QUO_W-1:0] RECIP_15 = 32'h4444_4445;
    localparam logic [QUO_W-1:0] RECIP_3  = 32'd349526;
    localparam logic [QUO_W-1:0] RECIP_7  = 32'd74899;

    // Calendar constants.
    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [YEAR_W-1:0] SKIP_CENTURY  = 12'd2100;
    localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY = 16'd4;
    localparam logic [YLEN_W-1:0] DAYS_LEAP     = 9'd366;
    localparam logic [YLEN_W-1:0] DAYS_COMMON   = 9'd365;

    // Month codes, counted from zero.
    localparam logic [MON_W-1:0] MON_JAN = 4'd0;
    localparam logic [MON_W-1:0] MON_FEB = 4'd1;
    localparam logic [MON_W-1:0] MON_APR = 4'd3;
    localparam logic [MON_W-1:0] MON_JUN = 4'd5;
    localparam logic [MON_W-1:0] MON_SEP = 4'd8;
    localparam logic [MON_W-1:0] MON_NOV = 4'd10;
    localparam logic [MON_W-1:0] MON_DEC = 4'd11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   start;
        logic   mul;
        logic   finish;
        t_phase phase;
        logic   year_step;
        logic   month_step;
        logic   out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_status;

    function automatic logic [REM_W-1:0] div_divisor(input t_phase p);
        logic [REM_W-1:0] d;
        unique case (p)
            PH_SEC:  d = SECS_PER_MIN;
            PH_MIN:  d = MINS_PER_HOUR;
            PH_HOUR: d = HOURS_PER_DAY;
            default: d = DAYS_PER_WEEK;
        endcase
        return d;
    endfunction

    // Within 1970 to 2106 the only centuries are 2000, which is a leap year,
    // and 2100, which is not.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != SKIP_CENTURY);
    endfunction

    function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] y);
        return is_leap(y) ? DAYS_LEAP : DAYS_COMMON;
    endfunction

    function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [MLEN_W-1:0] len;
        case (m) inside
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/ecd_dp.sv =====
// ----------------------------------------------------------------------------
// ecd_dp
// Datapath: a shared reciprocal-multiply divider by constants, the year and
// month walk registers and the result register.
// ----------------------------------------------------------------------------
module ecd_dp (
    input  logic                 i_clk,
    input  ecd_pkg::t_dp_cmd     i_cmd,
    output ecd_pkg::t_dp_status  o_status,
    input  logic [31:0]          i_epoch_seconds,
    output logic [5:0]           o_second,
    output logic [5:0]           o_minute,
    output logic [4:0]           o_hour,
    output logic [2:0]           o_weekday,
    output logic [4:0]           o_day_of_month,
    output logic [3:0]           o_month_number,
    output logic [11:0]          o_full_year
);
    import ecd_pkg::*;

    logic [QUO_W-1:0]  r_x;
    logic [QUO_W-1:0]  r_q;
    logic [5:0]        r_sec;
    logic [5:0]        r_min;
    logic [4:0]        r_hour;
    logic [2:0]        r_wday;
    logic [DAYS_W-1:0] r_days;
    logic [YEAR_W-1:0] r_year;
    logic [MON_W-1:0]  r_mon;

    logic [5:0]        r_out_second;
    logic [5:0]        r_out_minute;
    logic [4:0]        r_out_hour;
    logic [2:0]        r_out_weekday;
    logic [4:0]        r_out_day;
    logic [3:0]        r_out_month;
    logic [11:0]       r_out_year;

    logic [REM_W-1:0]   divisor;
    logic [QUO_W-1:0]   div_y;
    logic [QUO_W-1:0]   div_recip;
    logic [PROD_W-1:0]  div_prod;
    logic [QUO_W-1:0]   div_quo;
    logic [2*REM_W-1:0] qd_low;
    logic [REM_W-1:0]   rem;
    logic [DAYS_W-1:0]  wday_operand;
    logic [YLEN_W-1:0]  cur_year_len;
    logic [MLEN_W-1:0]  cur_month_len;

    // Quotient by reciprocal multiplication; the pre-shift removes the
    // power-of-two factor of the divisor.
    always_comb begin
        divisor = div_divisor(i_cmd.phase);
        unique case (i_cmd.phase) inside
            PH_SEC, PH_MIN: begin
                div_y     = {2'b00, r_x[QUO_W-1:2]};
                div_recip = RECIP_15;
            end
            PH_HOUR: begin
                div_y     = {3'b000, r_x[QUO_W-1:3]};
                div_recip = RECIP_3;
            end
            default: begin
                div_y     = r_x;
                div_recip = RECIP_7;
            end
        endcase
        div_prod = {32'd0, div_y} * {32'd0, div_recip};
        unique case (i_cmd.phase) inside
            PH_SEC, PH_MIN: div_quo = {2'b00, div_prod[63:34]};
            PH_HOUR:        div_quo = {12'd0, div_prod[39:20]};
            default:        div_quo = {13'd0, div_prod[37:19]};
        endcase
    end

    // The remainder is below 64, so only the low bits of x - q * d matter.
    assign qd_low = {6'd0, r_q[REM_W-1:0]} * {6'd0, divisor};
    assign rem    = r_x[REM_W-1:0] - qd_low[REM_W-1:0];

    // The weekday counts from a Thursday, so the day count is offset first.
    assign wday_operand = r_q[DAYS_W-1:0] + EPOCH_WEEKDAY;

    // Lengths for the year and month walks.
    assign cur_year_len  = year_len(r_year);
    assign cur_month_len = month_len(r_mon, is_leap(r_year));

    assign o_status.year_done  = r_days < DAYS_W'(cur_year_len);
    assign o_status.month_done = (r_days < DAYS_W'(cur_month_len)) || (r_mon == MON_DEC);

    // Divider, field capture and calendar walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x    <= i_epoch_seconds;
            r_year <= EPOCH_YEAR;
            r_mon  <= MON_JAN;
        end else if (i_cmd.mul) begin
            r_q <= div_quo;
        end else if (i_cmd.finish) begin
            unique case (i_cmd.phase)
                PH_SEC: begin
                    r_sec <= rem;
                    r_x   <= r_q;
                end
                PH_MIN: begin
                    r_min <= rem;
                    r_x   <= r_q;
                end
                PH_HOUR: begin
                    r_hour <= rem[4:0];
                    r_days <= r_q[DAYS_W-1:0];
                    r_x    <= QUO_W'(wday_operand);
                end
                default: begin
                    r_wday <= rem[2:0];
                end
            endcase
        end

        if (i_cmd.year_step) begin
            r_days <= r_days - DAYS_W'(cur_year_len);
            r_year <= r_year + 12'd1;
        end else if (i_cmd.month_step) begin
            r_days <= r_days - DAYS_W'(cur_month_len);
            r_mon  <= r_mon + 4'd1;
        end

        if (i_cmd.out_load) begin
            r_out_second  <= r_sec;
            r_out_minute  <= r_min;
            r_out_hour    <= r_hour;
            r_out_weekday <= r_wday;
            r_out_day     <= r_days[4:0] + 5'd1;
            r_out_month   <= r_mon + 4'd1;
            r_out_year    <= r_year;
        end
    end

    assign o_second       = r_out_second;
    assign o_minute       = r_out_minute;
    assign o_hour         = r_out_hour;
    assign o_weekday      = r_out_weekday;
    assign o_day_of_month = r_out_day;
    assign o_month_number = r_out_month;
    assign o_full_year    = r_out_year;

endmodule

// ===== rtl/ecd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecd_ctrl
// Controller: sequences the four divisions, the year walk and the month walk,
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module ecd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ecd_pkg::t_dp_status  i_status,
    output ecd_pkg::t_dp_cmd     o_cmd
);
    import ecd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_REM   = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              can_load;
    t_dp_cmd           cmd;

    // The result register is free when empty or being taken this cycle.
    assign can_load = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        cmd       = '0;
        cmd.phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_phase   = PH_SEC;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_REM;
            end
            S_REM: begin
                cmd.finish = 1'b1;
                if (r_phase == PH_WDAY) begin
                    n_state = S_YEAR;
                end else begin
                    n_phase = r_phase + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_YEAR: begin
                if (i_status.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (!i_status.month_done) begin
                    cmd.month_step = 1'b1;
                end else if (can_load) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (can_load) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load || (r_out_valid && !i_out_ready);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== rtl/epoch_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_core
// Converts a count of seconds since 1970-01-01 00:00:00 into second, minute,
// hour, weekday, day of month, month and full Gregorian year.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_epoch_seconds
// result    out        o_valid / i_ready  o_second .. o_full_year
//
// The four constant divisions share one reciprocal multiplier, each as a quotient
// step then a remainder step (S_MUL, S_REM). Then the year walk steps over Y, the
// number of whole years past 1970 (0 to 136), and the month walk over M, the month
// index (0 to 11), one year or month a cycle, each ending once the remaining days
// fit. One request is in flight at a time; the input reopens the cycle after
// the result is loaded, while the previous result may still wait in the output
// register. Reset is synchronous and clears only the control state. A stalled
// result holds the controller in S_HOLD until the register is free.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [11:0] o_full_year
);
    import ecd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    ecd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Divider, calendar walk and result register.
    ecd_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_epoch_seconds (i_epoch_seconds),
        .o_second        (o_second),
        .o_minute        (o_minute),
        .o_hour          (o_hour),
        .o_weekday       (o_weekday),
        .o_day_of_month  (o_day_of_month),
        .o_month_number  (o_month_number),
        .o_full_year     (o_full_year)
    );

endmodule

// ===== rtl/ecd_chk.sv =====
// ----------------------------------------------------------------------------
// ecd_chk
// Port-level checks for the epoch to calendar date converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module ecd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [2:0]  o_weekday,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month_number,
    input logic [11:0] o_full_year
);

    // Every presented result has each field within its calendar range.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second < 6'd60) && (o_minute < 6'd60) && (o_hour < 5'd24)
                    && (o_weekday < 3'd7) && (o_day_of_month != 5'd0)
                    && (o_month_number != 4'd0) && (o_month_number < 4'd13)
                    && (o_full_year >= 12'd1970) && (o_full_year <= 12'd2106))
        else $error("result field out of calendar range");

    // Only one request is in flight at a time, so input is closed right after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still open the cycle after a request was accepted");

    // A stalled result stays presented and unchanged.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_second) && $stable(o_minute)
                                  && $stable(o_hour) && $stable(o_weekday)
                                  && $stable(o_day_of_month)
                                  && $stable(o_month_number) && $stable(o_full_year))
        else $error("stalled result changed or was dropped");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind epoch_to_calendar_date_core ecd_chk u_ecd_chk (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the epoch seconds to calendar date converter. Each
// accepted request is converted by an independent calendar predictor and the
// returned date and time are compared field by field, in order. The stimulus
// covers the ends of the 32-bit range, leap days around 2000 and 2100, and
// random timestamps under three pacing regimes and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected calendar fields for one request.
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] full_year;
    } t_calendar;

    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned LAST_EPOCH_DAY = 49710;
    localparam int unsigned LONG_HOLD      = 600;
    localparam int unsigned RANDOM_PER_ACT = 334;
    localparam int unsigned DRAIN_CYCLES   = 250;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_number;
    logic [11:0] o_full_year;

    logic [31:0] pending_stamps [$];
    t_calendar   expected_dates [$];
    logic        req_taken     = 1'b0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    logic        long_hold_req = 1'b0;
    logic        hold_done     = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned requests_sent = 0;
    int unsigned dates_checked = 0;
    int unsigned late_years    = 0;
    int unsigned error_count   = 0;

    epoch_to_calendar_date_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_second        (o_second),
        .o_minute        (o_minute),
        .o_hour          (o_hour),
        .o_weekday       (o_weekday),
        .o_day_of_month  (o_day_of_month),
        .o_month_number  (o_month_number),
        .o_full_year     (o_full_year)
    );

    // Full Gregorian rule: centuries are leap years only when divisible by 400.
    function automatic logic is_leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Splits a timestamp into time of day, weekday, then walks years and months.
    function automatic t_calendar epoch_to_date(input logic [31:0] stamp);
        t_calendar   cal;
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned ylen;
        int unsigned mlen;
        t = stamp;
        cal.second = 6'(t % 60);
        t = t / 60;
        cal.minute = 6'(t % 60);
        t = t / 60;
        cal.hour = 5'(t % 24);
        days = t / 24;
        // 1970-01-01 fell on a Thursday.
        cal.weekday = 3'((days + 4) % 7);
        yr = 1970;
        ylen = is_leap_year(yr) ? 366 : 365;
        while (days >= ylen) begin
            days = days - ylen;
            yr = yr + 1;
            ylen = is_leap_year(yr) ? 366 : 365;
        end
        mon = 0;
        mlen = MONTH_DAYS[0];
        while (days >= mlen && mon < 11) begin
            days = days - mlen;
            mon = mon + 1;
            mlen = (mon == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[mon];
        end
        cal.day_of_month = 5'(days + 1);
        cal.month_number = 4'(mon + 1);
        cal.full_year = 12'(yr);
        return cal;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Request driver: a new timestamp is offered once the previous one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_stamps.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_valid         <= 1'b1;
                i_epoch_seconds <= pending_stamps.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: check returned dates first, then record newly accepted requests.
    always @(posedge i_clk) begin
        t_calendar want;
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d-%0d-%0d", $time,
                         o_full_year, o_month_number, o_day_of_month);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("second", 32'(want.second), 32'(o_second));
                check_field("minute", 32'(want.minute), 32'(o_minute));
                check_field("hour", 32'(want.hour), 32'(o_hour));
                check_field("weekday", 32'(want.weekday), 32'(o_weekday));
                check_field("day_of_month", 32'(want.day_of_month), 32'(o_day_of_month));
                check_field("month_number", 32'(want.month_number), 32'(o_month_number));
                check_field("full_year", 32'(want.full_year), 32'(o_full_year));
                dates_checked++;
                if (want.full_year >= 12'd2100) begin
                    late_years++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected_dates.push_back(epoch_to_date(i_epoch_seconds));
            requests_sent++;
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [63:0] near_midnight;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed timestamps: range ends, unit roll-overs and leap days.
        pending_stamps = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                           32'd86399, 32'd86400,
                           32'd31535999, 32'd31536000,   // end of 1970, start of 1971
                           32'd94608000, 32'd94694399,   // 31 December of leap 1972
                           32'd951782399, 32'd951782400, // 29 February 2000
                           32'd951868800,                // 1 March 2000
                           32'd4107456000,               // 28 February 2100
                           32'd4107542399, 32'd4107542400, // 2100 skips its leap day
                           32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'h8000_0000, 32'h7FFF_FFFF};

        // Three pacing regimes, each with its share of random timestamps.
        for (int act = 0; act < 3; act++) begin
            if (act == 0) begin
                tx_idle_pct = 16;
                rx_idle_pct = 79;
            end else if (act == 1) begin
                tx_idle_pct = 79;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct   = 0;
                rx_idle_pct   = 0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_ACT; n++) begin
                case ($urandom_range(4))
                    0: pending_stamps.push_back($urandom_range(200000000));
                    1: begin
                        near_midnight = 64'($urandom_range(LAST_EPOCH_DAY)) * SECS_PER_DAY
                                        + ($urandom_range(1) ? 64'd0 : 64'd86399);
                        pending_stamps.push_back(near_midnight[31:0]);
                    end
                    default: pending_stamps.push_back($urandom);
                endcase
            end
            while (pending_stamps.size() > 0 || i_valid) begin
                @(posedge i_clk);
            end
        end

        while (expected_dates.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d timestamps and checked %0d dates, %0d of them in 2100 or later,",
                 requests_sent, dates_checked, late_years);
        $display("under three pacing regimes with one long output stall.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #6000000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
